FILE: src/bsbe_pkg.sv
// Package for the big-endian byte stack: opcodes, status codes, the command
// record passed from the front end to the back end, and state encodings.
// No dependencies.
package bsbe_pkg;

    localparam int CNT_W  = 12;
    localparam int DATA_W = 64;
    localparam int FILL_W = 12;
    localparam int NBANK  = 8;

    // Wide enough for the largest supported stack (65536 bytes).
    localparam int ADDR_W = 16;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [1:0] OP_PUSH_VAL   = 2'd0;
    localparam logic [1:0] OP_POP_VAL    = 2'd1;
    localparam logic [1:0] OP_PUSH_ZERO  = 2'd2;
    localparam logic [1:0] OP_POP_BYTES  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BURST     = 2'd3;

    typedef enum logic [2:0] {
        K_REPORT,
        K_PUSH_VAL,
        K_POP_VAL,
        K_PUSH_ZERO,
        K_POP_BYTES
    } bsbe_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_BYTES,
        BK_EMIT
    } bsbe_state_t;

    typedef struct packed {
        bsbe_kind_t         kind;
        logic [1:0]         size_code;
        logic               sign_extend;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   count;
        logic [ADDR_W-1:0]  addr;
        logic [1:0]         status;
        logic [FILL_W-1:0]  fill;
    } bsbe_cmd_t;

endpackage

FILE: src/bsbe_ifs.sv
// Valid/ready channel interfaces for the byte stack: the request channel
// and the result channel. No dependencies.
interface bsbe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  size_code;
    logic        sign_extend;
    logic [63:0] push_data;
    logic [11:0] count;

    modport source (output valid, op, size_code, sign_extend, push_data, count,
                    input ready);
    modport sink   (input valid, op, size_code, sign_extend, push_data, count,
                    output ready);
endinterface

interface bsbe_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out;
    logic [1:0]  status;
    logic [11:0] fill;
    logic        last;

    modport source (output valid, data_out, status, fill, last, input ready);
    modport sink   (input valid, data_out, status, fill, last, output ready);
endinterface

FILE: src/bsbe_front.sv
// Front end of the byte stack: accepts requests, owns the fill count, checks
// for overflow, underflow and overlong bursts, and issues commands.
// Depends on bsbe_pkg and bsbe_in_if.
module bsbe_front
    import bsbe_pkg::*;
#(
    parameter int STACK_BYTES = 4096,
    parameter int MAX_BURST   = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    bsbe_in_if.sink   cmd,
    output logic      q_valid,
    output bsbe_cmd_t q_cmd,
    input  logic      q_ready
);

    localparam int AW = $clog2(STACK_BYTES);
    localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam logic [SW-1:0] CAP = SW'(STACK_BYTES);

    logic [AW-1:0] fill_reg;
    logic [AW-1:0] fill_next;
    logic [SW-1:0] fill_w;
    logic [SW-1:0] need_w;
    logic [SW-1:0] sum_w;
    logic [SW-1:0] diff_w;
    logic          accept;
    bsbe_cmd_t     cmd_c;

    assign accept  = cmd.valid && q_ready;
    assign cmd.ready = q_ready;
    assign q_valid = cmd.valid;
    assign q_cmd   = cmd_c;

    always_comb
    begin
        fill_w = SW'(fill_reg);
        if (cmd.op == OP_PUSH_VAL || cmd.op == OP_POP_VAL)
        begin
            need_w = SW'(4'd1 << cmd.size_code);
        end
        else
        begin
            need_w = SW'(cmd.count);
        end
        sum_w  = fill_w + need_w;
        diff_w = fill_w - need_w;

        fill_next         = fill_reg;
        cmd_c.kind        = K_REPORT;
        cmd_c.size_code   = cmd.size_code;
        cmd_c.sign_extend = cmd.sign_extend;
        cmd_c.data        = cmd.push_data;
        cmd_c.count       = cmd.count;
        cmd_c.addr        = ADDR_W'(fill_reg);
        cmd_c.status      = ST_OK;

        case (cmd.op)
            OP_PUSH_VAL, OP_PUSH_ZERO:
            begin
                if (sum_w >= CAP)
                begin
                    cmd_c.status = ST_OVERFLOW;
                end
                else if (need_w != '0)
                begin
                    cmd_c.kind = (cmd.op == OP_PUSH_VAL) ? K_PUSH_VAL : K_PUSH_ZERO;
                    fill_next  = AW'(sum_w);
                end
            end
            OP_POP_VAL, OP_POP_BYTES:
            begin
                if (cmd.op == OP_POP_BYTES && cmd.count > CNT_W'(MAX_BURST))
                begin
                    cmd_c.status = ST_BURST;
                end
                else if (fill_w < need_w)
                begin
                    cmd_c.status = ST_UNDERFLOW;
                end
                else if (need_w != '0)
                begin
                    cmd_c.kind = (cmd.op == OP_POP_VAL) ? K_POP_VAL : K_POP_BYTES;
                    fill_next  = AW'(diff_w);
                    cmd_c.addr = ADDR_W'(fill_next);
                end
            end
            default:
            begin
                cmd_c.status = ST_OK;
            end
        endcase
        cmd_c.fill = FILL_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    a_fill_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(fill_reg) < CAP)
        else $error("Stack fill reached capacity.");

endmodule

FILE: src/bsbe_queue.sv
// Two-entry command queue between the front end and the back end of the
// byte stack. Depends on bsbe_pkg.
module bsbe_queue
    import bsbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  bsbe_cmd_t in_cmd,
    output logic      in_ready,
    output logic      out_valid,
    output bsbe_cmd_t out_cmd,
    input  logic      out_ready
);

    bsbe_cmd_t          ent_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != QCNT_W'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("Command queue holds more entries than it has.");

endmodule

FILE: src/bsbe_back.sv
// Back end of the byte stack: executes commands against eight byte-wide
// memory banks and drives the registered result channel.
// Depends on bsbe_pkg and bsbe_out_if.
module bsbe_back
    import bsbe_pkg::*;
#(
    parameter int STACK_BYTES = 4096
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  bsbe_cmd_t cmd_in,
    output logic      cmd_ready,
    bsbe_out_if.source res
);

    localparam int AW    = $clog2(STACK_BYTES);
    localparam int DEPTH = (STACK_BYTES + 7) / 8;
    localparam int RW    = $clog2(DEPTH);

    bsbe_state_t         state_reg;
    bsbe_state_t         state_next;
    bsbe_cmd_t           cmd_reg;
    logic [AW-1:0]       addr_reg;
    logic [CNT_W-1:0]    remain_reg;
    logic [2:0]          lane_reg;
    logic [7:0]          mem [NBANK][DEPTH];
    logic [7:0]          rdata_reg [NBANK];

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [1:0]          out_status_reg;
    logic [FILL_W-1:0]   out_fill_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                out_load;
    logic                fetch;
    logic                byte_rd;
    logic                byte_last;
    logic                more_zero;
    logic [2:0]          lane;
    logic [RW-1:0]       row_base;
    logic [3:0]          chunk;
    logic [3:0]          nbytes;
    logic [3:0]          adv;
    logic [CNT_W-1:0]    rem_dec;
    logic [DATA_W-1:0]   d8;
    logic [DATA_W-1:0]   v8;
    logic [DATA_W-1:0]   popv;
    logic [DATA_W-1:0]   res_data;
    logic                sx;
    logic                we [NBANK];
    logic                re [NBANK];
    logic [7:0]          wdata [NBANK];
    logic [RW-1:0]       row [NBANK];
    logic [2:0]          idx [NBANK];

    assign out_free  = !out_valid_reg || res.ready;
    assign lane      = addr_reg[2:0];
    assign row_base  = RW'(addr_reg >> 3);
    assign chunk     = (remain_reg >= CNT_W'(8)) ? 4'd8 : 4'(remain_reg);
    assign nbytes    = 4'd1 << cmd_reg.size_code;
    assign byte_last = (remain_reg == CNT_W'(1));
    assign more_zero = (remain_reg > CNT_W'(8));

    always_comb
    begin
        case (cmd_reg.size_code)
            2'd0:    d8 = {cmd_reg.data[7:0], 56'd0};
            2'd1:    d8 = {cmd_reg.data[15:0], 48'd0};
            2'd2:    d8 = {cmd_reg.data[31:0], 32'd0};
            default: d8 = cmd_reg.data;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NBANK; i++)
        begin
            v8[8*(7-i) +: 8] = rdata_reg[3'(cmd_reg.addr[2:0] + 3'(i))];
        end
        sx = cmd_reg.sign_extend & v8[63];
        case (cmd_reg.size_code)
            2'd0:    popv = {{56{sx}}, v8[63:56]};
            2'd1:    popv = {{48{sx}}, v8[63:48]};
            2'd2:    popv = {{32{sx}}, v8[63:32]};
            default: popv = v8;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                case (cmd_reg.kind)
                    K_PUSH_ZERO:
                    begin
                        if (!more_zero)
                        begin
                            state_next = BK_EMIT;
                        end
                    end
                    K_POP_BYTES: state_next = BK_BYTES;
                    default:     state_next = BK_EMIT;
                endcase
            end
            BK_BYTES:
            begin
                if (out_free && byte_last)
                begin
                    state_next = cmd_valid ? BK_EXEC : BK_IDLE;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = cmd_valid ? BK_EXEC : BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        out_load  = 1'b0;
        byte_rd   = 1'b0;
        adv       = 4'd0;
        rem_dec   = '0;
        for (int b = 0; b < NBANK; b++)
        begin
            idx[b]   = 3'(3'(b) - lane);
            row[b]   = row_base + RW'(3'(b) < lane);
            we[b]    = 1'b0;
            re[b]    = 1'b0;
            wdata[b] = 8'd0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            BK_EXEC:
            begin
                case (cmd_reg.kind)
                    K_PUSH_VAL:
                    begin
                        for (int b = 0; b < NBANK; b++)
                        begin
                            we[b]    = ({1'b0, idx[b]} < nbytes);
                            wdata[b] = d8[8*(7-idx[b]) +: 8];
                        end
                    end
                    K_PUSH_ZERO:
                    begin
                        for (int b = 0; b < NBANK; b++)
                        begin
                            we[b] = ({1'b0, idx[b]} < chunk);
                        end
                        adv     = chunk;
                        rem_dec = CNT_W'(chunk);
                    end
                    K_POP_VAL:
                    begin
                        for (int b = 0; b < NBANK; b++)
                        begin
                            re[b] = 1'b1;
                        end
                    end
                    K_POP_BYTES:
                    begin
                        byte_rd = 1'b1;
                        adv     = 4'd1;
                    end
                    default:
                    begin
                        adv = 4'd0;
                    end
                endcase
            end
            BK_BYTES:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    rem_dec  = CNT_W'(1);
                    if (byte_last)
                    begin
                        cmd_ready = 1'b1;
                    end
                    else
                    begin
                        byte_rd = 1'b1;
                        adv     = 4'd1;
                    end
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    cmd_ready = 1'b1;
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase

        if (byte_rd)
        begin
            for (int b = 0; b < NBANK; b++)
            begin
                re[b] = (3'(b) == lane);
            end
        end

        fetch = cmd_ready && cmd_valid;

        if (state_reg == BK_BYTES)
        begin
            res_data = {56'd0, rdata_reg[lane_reg]};
        end
        else if (cmd_reg.kind == K_POP_VAL)
        begin
            res_data = popv;
        end
        else
        begin
            res_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NBANK; b++)
        begin
            if (we[b])
            begin
                mem[b][row[b]] <= wdata[b];
            end
            if (re[b])
            begin
                rdata_reg[b] <= mem[b][row[b]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            cmd_reg    <= cmd_in;
            addr_reg   <= AW'(cmd_in.addr);
            remain_reg <= cmd_in.count;
        end
        else
        begin
            addr_reg   <= addr_reg + AW'(adv);
            remain_reg <= remain_reg - rem_dec;
        end
        if (byte_rd)
        begin
            lane_reg <= lane;
        end
        if (out_load)
        begin
            out_data_reg   <= res_data;
            out_status_reg <= cmd_reg.status;
            out_fill_reg   <= cmd_reg.fill;
            out_last_reg   <= (state_reg == BK_EMIT) || byte_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.data_out = out_data_reg;
    assign res.status   = out_status_reg;
    assign res.fill     = out_fill_reg;
    assign res.last     = out_last_reg;

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != ST_OK |-> res.last)
        else $error("Error result not marked as last.");

    a_bytes_remain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_BYTES |-> remain_reg != '0)
        else $error("Byte burst running with nothing left to pop.");

    a_report_emits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_EXEC && cmd_reg.kind == K_REPORT |=> state_reg == BK_EMIT)
        else $error("Status-only command did not go to result output.");

endmodule

FILE: src/byte_stack_big_endian_push_pop.sv
// Byte-addressed big-endian stack: a front end checks each request against the
// fill count, a two-entry queue holds commands, and a back end works on eight
// byte-wide memory banks, so one cycle reaches any eight consecutive bytes.
// Rate: the front end takes one request per cycle while the queue has room.
// The back end runs a push value, a pop value or any request that only reports
// a status as an execute step then an emit step, writes a push zeroes in chunks
// of up to eight bytes before the emit, and returns a pop bytes burst one result
// per cycle while the result channel accepts it; each bank has a single port.
// The memory is not cleared; popping bytes that were never pushed returns
// undefined data. Depends on bsbe_pkg and the channel interfaces in bsbe_ifs.
module byte_stack_big_endian_push_pop
    import bsbe_pkg::*;
#(
    parameter int STACK_BYTES = 4096,
    parameter int MAX_BURST   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    bsbe_in_if.sink     cmd,
    bsbe_out_if.source  res
);

    logic      fq_valid;
    logic      fq_ready;
    bsbe_cmd_t fq_cmd;
    logic      qb_valid;
    logic      qb_ready;
    bsbe_cmd_t qb_cmd;

    bsbe_front #(
        .STACK_BYTES (STACK_BYTES),
        .MAX_BURST   (MAX_BURST)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (fq_valid),
        .q_cmd   (fq_cmd),
        .q_ready (fq_ready)
    );

    bsbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_cmd    (fq_cmd),
        .in_ready  (fq_ready),
        .out_valid (qb_valid),
        .out_cmd   (qb_cmd),
        .out_ready (qb_ready)
    );

    bsbe_back #(
        .STACK_BYTES (STACK_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_in    (qb_cmd),
        .cmd_ready (qb_ready),
        .res       (res)
    );

endmodule
